/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants of the sorted priority queue
// Queue depth, pointer widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int KEY_W  = 32;
   localparam int TAG_W  = 32;
   localparam int ENT_W  = KEY_W + TAG_W;

   // operation codes (req_tuser)
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // status codes (rsp_tuser[1:0])
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CMP  = 5'b00010,
      ST_WNEW = 5'b00100,
      ST_HEAD = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // one memory write request
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [ENT_W-1:0] data;
   } wr_req_type;

endpackage

`default_nettype wire

/* rtl/sorted_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_top - bounded priority queue with sorted storage
// Insert / pop-smallest / clear over a stream interface, one result per beat.
// ----------------------------------------------------------------------------
// Entries (signed Q16.16 key plus 32-bit tag) sit in a circular buffer in one
// RAM, ascending from the head pointer. A pop only advances the head, so pop
// and clear go straight from accept to result; refused inserts and the unused
// kind read the head in between (accept, head read, result). An insert walks
// from the tail toward the head with one signed compare a cycle, moving each
// larger entry up one slot, then writes the new entry, reads the head and
// gives its result. The single RAM port pair and the one comparator set the
// pace of the walk. Equal keys stay in arrival order. A finished result
// waits in the output register while the next beat may already be taken; if
// that result is still unaccepted when the next one is ready, the sequencer
// holds in its last state until the output register is free. req_tready is
// high only when idle. No clearing pass after reset: only slots holding live
// entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // key[31:0], tag[63:32]
   input  wire logic [1:0]  req_tuser,   // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // out_key[31:0], out_tag[63:32],
                                         // count[70:64], zero[71]
   output logic [2:0]       rsp_tuser    // status[1:0], out_valid[2]
);

   import spq_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] slot_ff, slot_in;      // hole that the walk fills next
   logic [CNT_W-1:0] left_ff, left_in;      // entries not yet compared
   logic [KEY_W-1:0] new_key_ff, new_key_in;
   logic [TAG_W-1:0] new_tag_ff, new_tag_in;
   logic [1:0]       status_ff, status_in;
   logic             popped_ff, popped_in;  // result shows a popped entry

   logic             rsp_valid_ff, rsp_valid_in;
   logic [71:0]      rsp_data_ff, rsp_data_in;
   logic [2:0]       rsp_user_ff, rsp_user_in;

   wr_req_type       wr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENT_W-1:0] rd_data;

   logic             accept;
   logic [1:0]       kind;
   logic [SUM_W-1:0] tail_sum;
   logic [IDX_W-1:0] tail_idx, tail_m1, slot_m1, slot_m2, head_p1;
   logic             key_less;
   logic             out_free;
   logic             show;
   logic [CNT_W+6:0] cnt_wide;

   function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] i);
      dec_idx = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
   endfunction

   assign accept   = req_tvalid && req_tready;
   assign kind     = req_tuser;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // physical slot just past the last entry
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(cnt_ff);
   assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);
   assign tail_m1  = dec_idx(tail_idx);
   assign slot_m1  = dec_idx(slot_ff);
   assign slot_m2  = dec_idx(slot_m1);
   assign head_p1  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);

   // the shared comparator: new key strictly below the stored one
   assign key_less = $signed(new_key_ff) < $signed(rd_data[KEY_W-1:0]);

   assign show     = popped_ff || (cnt_ff != '0);
   assign cnt_wide = {7'd0, cnt_ff};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      left_in      = left_ff;
      new_key_in   = new_key_ff;
      new_tag_in   = new_tag_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr           = '0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      req_tready   = 1'b0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               new_key_in = req_tdata[31:0];
               new_tag_in = req_tdata[63:32];
               status_in  = STAT_OK;
               popped_in  = 1'b0;
               case (kind)
                  KIND_INSERT: begin
                     if (cnt_ff >= CNT_W'(DEPTH)) begin
                        status_in = STAT_FULL;
                        state_in  = ST_HEAD;
                     end else begin
                        cnt_in  = cnt_ff + CNT_W'(1);
                        slot_in = tail_idx;
                        left_in = cnt_ff;
                        if (cnt_ff == '0) begin
                           state_in = ST_WNEW;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = tail_m1;
                           state_in = ST_CMP;
                        end
                     end
                  end
                  KIND_POP: begin
                     if (cnt_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = head_ff;
                        head_in   = head_p1;
                        cnt_in    = cnt_ff - CNT_W'(1);
                        popped_in = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  KIND_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_HEAD;
                  end
               endcase
            end
         end

         ST_CMP: begin
            // rd_data holds the entry just below the hole
            if (key_less) begin
               wr.en   = 1'b1;
               wr.addr = slot_ff;
               wr.data = rd_data;
               slot_in = slot_m1;
               left_in = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_WNEW;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_m2;
               end
            end else begin
               wr.en    = 1'b1;
               wr.addr  = slot_ff;
               wr.data  = {new_tag_ff, new_key_ff};
               state_in = ST_HEAD;
            end
         end

         ST_WNEW: begin
            wr.en    = 1'b1;
            wr.addr  = slot_ff;
            wr.data  = {new_tag_ff, new_key_ff};
            state_in = ST_HEAD;
         end

         ST_HEAD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in        = '0;
               rsp_data_in[70:64] = cnt_wide[6:0];
               if (show) begin
                  rsp_data_in[63:0] = rd_data;
               end
               rsp_user_in = {show, status_ff};
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      left_ff     <= left_in;
      new_key_ff  <= new_key_in;
      new_tag_ff  <= new_tag_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   spq_ram #(
      .W (ENT_W),
      .D (DEPTH),
      .AW(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr.en),
      .wr_addr(wr.addr),
      .wr_data(wr.data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

/* rtl/spq_ram.sv */
// ----------------------------------------------------------------------------
// spq_ram - entry storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
   parameter int W  = 64,
   parameter int D  = 64,
   parameter int AW = (D > 2) ? $clog2(D) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [W-1:0]  wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [W-1:0]  rd_data
);

   logic [W-1:0] mem [D];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
